### design/assert_macros.svh
// Assertion macros used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cq_pkg.sv
// Types, constants and helper functions for the circular queue.
package cq_pkg;

  localparam int MaxSlots = 16;
  localparam int PtrW     = $clog2(MaxSlots);
  localparam int CntW     = $clog2(MaxSlots + 1);
  localparam int OffW     = 4;
  localparam int DataW    = 32;
  localparam int CapW     = 5;
  localparam int SumW     = ((PtrW > OffW) ? PtrW : OffW) + 1;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  // Operation codes carried by in_kind
  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  // Slot store access for one cycle
  typedef struct packed {
    logic                    we;
    ptr_t                    waddr;
    logic signed [DataW-1:0] wdata;
    logic                    re;
    ptr_t                    raddr;
  } mem_req_t;

  // Clamp the capacity register to the range the ring supports
  function automatic cnt_t eff_cap(input logic [CapW-1:0] v);
    cnt_t res;
    if (v == '0) begin
      res = cnt_t'(1);
    end else if (CntW'(v) > cnt_t'(MaxSlots) || v > CapW'(MaxSlots)) begin
      res = cnt_t'(MaxSlots);
    end else begin
      res = cnt_t'(v);
    end
    return res;
  endfunction

  // Advance a ring pointer, wrapping at the capacity in use
  function automatic ptr_t ptr_wrap(input ptr_t p, input cnt_t cap);
    cnt_t inc;
    inc = cnt_t'(p) + cnt_t'(1);
    return (inc >= cap) ? '0 : inc[PtrW-1:0];
  endfunction

endpackage

### design/circular_queue_with_indexed_read.sv
// One result per operation, on the ports in the cycle after the start transfer.
// Throughput: one operation per cycle; busy stays low, so start may be held high.
// The slot store has a single registered read port, shared by pop and indexed read.
// Reset (synchronous, rst_n low): queue empty, capacity 16, no result pending.
// A capacity write empties the queue; slot contents are undefined until pushed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circular_queue_with_indexed_read
  import cq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic signed [DataW-1:0] in_push_value,
  input  logic [OffW-1:0]         in_offset,
  output logic                    out_strobe,
  output logic signed [DataW-1:0] out_read_data,
  output logic                    out_read_valid,
  output logic                    out_push_accepted,
  output logic [CntW-1:0]         out_entry_count,
  output logic signed [DataW-1:0] out_head_value,
  output logic signed [DataW-1:0] out_tail_value,
  output logic                    out_not_empty,
  input  logic                    cfg_we,
  input  logic [CapW-1:0]         cfg_wdata
);

  `include "assert_macros.svh"

  // Architectural state
  logic [CapW-1:0]         cap_r;
  ptr_t                    head_r, head_nxt;
  ptr_t                    tail_r, tail_nxt;
  cnt_t                    cnt_r, cnt_nxt;
  logic signed [DataW-1:0] head_val_r, head_val_nxt;
  logic signed [DataW-1:0] tail_val_r, tail_val_nxt;
  logic                    hsel_r, hsel_nxt;

  // Result register
  logic                    strobe_r;
  logic signed [DataW-1:0] odata_r, odata_nxt;
  logic                    odsel_r, odsel_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic                    oacc_r, oacc_nxt;

  logic                    accept;
  cnt_t                    cap_eff;
  cnt_t                    cfg_cap;
  ptr_t                    head_inc, tail_inc;
  logic [SumW-1:0]         rd_sum;
  ptr_t                    rd_addr;
  logic signed [DataW-1:0] rd_data;
  logic signed [DataW-1:0] head_cur;
  mem_req_t                mreq;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign cap_eff  = eff_cap(cap_r);
  assign cfg_cap  = eff_cap(cfg_wdata);
  assign head_inc = ptr_wrap(head_r, cap_eff);
  assign tail_inc = ptr_wrap(tail_r, cap_eff);

  // Head word lives in the read register just after a pop
  assign head_cur = hsel_r ? rd_data : head_val_r;

  // Wrapped offset from head; only used when offset is below count, so one subtract
  assign rd_sum  = SumW'(head_r) + SumW'(in_offset);
  assign rd_addr = (rd_sum >= SumW'(cap_eff)) ? PtrW'(rd_sum - SumW'(cap_eff))
                                              : PtrW'(rd_sum);

  // Operation decode and next state
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    head_val_nxt = head_cur;
    tail_val_nxt = tail_val_r;
    hsel_nxt     = 1'b0;
    odata_nxt    = '0;
    odsel_nxt    = 1'b0;
    ovalid_nxt   = 1'b0;
    oacc_nxt     = 1'b0;
    mreq         = '0;
    mreq.waddr   = tail_inc;
    mreq.wdata   = in_push_value;
    mreq.raddr   = rd_addr;
    unique case (in_kind)
      KIND_PUSH: begin
        if (cnt_r < cap_eff) begin
          mreq.we      = 1'b1;
          tail_nxt     = tail_inc;
          cnt_nxt      = cnt_r + cnt_t'(1);
          tail_val_nxt = in_push_value;
          oacc_nxt     = 1'b1;
          if (cnt_r == '0) begin
            head_val_nxt = in_push_value;
          end
        end
      end
      KIND_POP: begin
        if (cnt_r != '0) begin
          odata_nxt  = head_cur;
          ovalid_nxt = 1'b1;
          head_nxt   = head_inc;
          cnt_nxt    = cnt_r - cnt_t'(1);
          // Fetch the new head word from the slot store
          mreq.raddr = head_inc;
          mreq.re    = (cnt_r != cnt_t'(1));
          hsel_nxt   = (cnt_r != cnt_t'(1));
        end
      end
      KIND_READ: begin
        if (cnt_t'(in_offset) < cnt_r) begin
          mreq.re    = 1'b1;
          odsel_nxt  = 1'b1;
          ovalid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      mreq.we = 1'b0;
      mreq.re = 1'b0;
    end
  end

  cq_slots u_slots (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // Queue state, capacity and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CapW'(MaxSlots);
      head_r   <= '0;
      tail_r   <= PtrW'(MaxSlots - 1);
      cnt_r    <= '0;
      hsel_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else if (cfg_we) begin
      cap_r    <= cfg_wdata;
      head_r   <= '0;
      tail_r   <= PtrW'(cfg_cap - cnt_t'(1));
      cnt_r    <= '0;
      hsel_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
        hsel_r <= hsel_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      head_val_r <= head_val_nxt;
      tail_val_r <= tail_val_nxt;
      odata_r    <= odata_nxt;
      odsel_r    <= odsel_nxt;
      ovalid_r   <= ovalid_nxt;
      oacc_r     <= oacc_nxt;
    end
  end

  // Result ports: state holds until the next transfer, so it is read directly
  assign out_strobe        = strobe_r;
  assign out_read_valid    = ovalid_r;
  assign out_push_accepted = oacc_r;
  assign out_read_data     = odsel_r ? rd_data : odata_r;
  assign out_entry_count   = cnt_r;
  assign out_not_empty     = (cnt_r != '0);
  assign out_head_value    = out_not_empty ? head_cur : '0;
  assign out_tail_value    = out_not_empty ? tail_val_r : '0;

  // Checks
  `CQ_ASSERT(a_cnt_in_cap, cnt_r <= cap_eff, "entry count above capacity")
  `CQ_ASSERT(a_ptr_in_cap, (cnt_t'(head_r) < cap_eff) && (cnt_t'(tail_r) < cap_eff), "pointer beyond capacity")
  `CQ_ASSERT(a_strobe_follows, (accept && !cfg_we) |=> strobe_r, "transfer without a result")
  `CQ_ASSERT(a_push_grows, (accept && mreq.we) |=> (cnt_r == $past(cnt_r) + cnt_t'(1)), "push did not grow count")
  `CQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !strobe_r, "result after reset")

endmodule

### design/cq_slots.sv
// Slot store: one write port and one registered read port.
module cq_slots
  import cq_pkg::*;
(
  input  logic                    clk,
  input  mem_req_t                req,
  output logic signed [DataW-1:0] rd_data
);

  logic signed [DataW-1:0] mem [MaxSlots];
  logic signed [DataW-1:0] rd_data_r;

  // Write on push, read only on an accepted operation so the data holds
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the circular queue with indexed read.
`timescale 1ns / 1ps

module tb_top;
  import cq_pkg::*;

  // Kind code with no operation behind it
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int         PhaseCount = 10;
  localparam int         PhaseOps   = 130;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic                    valid;
    logic                    accepted;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] head;
    logic signed [DataW-1:0] tail;
    logic                    not_empty;
  } queue_result_t;

  // One directed operation; quiet rows expect the all-zero result on an empty queue
  typedef struct packed {
    logic                    wr_cap;
    logic [CapW-1:0]         cap;
    logic [1:0]              kind;
    logic signed [DataW-1:0] value;
    logic [OffW-1:0]         off;
    logic                    quiet;
  } op_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_kind = KIND_PUSH;
  logic signed [DataW-1:0] in_push_value = '0;
  logic [OffW-1:0]         in_offset = '0;
  logic                    out_strobe;
  logic signed [DataW-1:0] out_read_data;
  logic                    out_read_valid;
  logic                    out_push_accepted;
  logic [CntW-1:0]         out_entry_count;
  logic signed [DataW-1:0] out_head_value;
  logic signed [DataW-1:0] out_tail_value;
  logic                    out_not_empty;
  logic                    cfg_we = 1'b0;
  logic [CapW-1:0]         cfg_wdata = '0;
  logic                    quiet_op = 1'b0;

  // Mirror of the queue state
  logic signed [DataW-1:0] ring [MaxSlots];
  logic [CapW-1:0]         cap_reg = CapW'(MaxSlots);
  int                      head_q = 0;
  int                      tail_q = MaxSlots - 1;
  int                      fill = 0;

  queue_result_t pending_results [$];
  int            errors = 0;
  int            ops_sent = 0;
  int            results_seen = 0;
  int            burst_left = 0;
  bit            filling = 1'b1;

  op_row_t dir_ops [25] = '{
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b1},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd0,  1'b1},
    '{1'b0, 5'd0,  KindUnused, 32'sh0,        4'd0,  1'b1},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd15, 1'b1},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh80000000, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh7fffffff, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'shffffffff, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd3,  1'b0},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd4,  1'b0},
    '{1'b0, 5'd0,  KindUnused, 32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd15, 1'b0},
    '{1'b1, 5'd2,  KIND_PUSH,  32'shaaaaaaaa, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh12345678, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh0badf00d, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_READ,  32'sh0,        4'd1,  1'b0},
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh55555555, 4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_POP,   32'sh0,        4'd0,  1'b0},
    '{1'b1, 5'd1,  KIND_PUSH,  32'sh1,        4'd0,  1'b0},
    '{1'b0, 5'd0,  KIND_PUSH,  32'sh2,        4'd0,  1'b0}
  };

  circular_queue_with_indexed_read dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_push_value     (in_push_value),
    .in_offset         (in_offset),
    .out_strobe        (out_strobe),
    .out_read_data     (out_read_data),
    .out_read_valid    (out_read_valid),
    .out_push_accepted (out_push_accepted),
    .out_entry_count   (out_entry_count),
    .out_head_value    (out_head_value),
    .out_tail_value    (out_tail_value),
    .out_not_empty     (out_not_empty),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("Regression FAIL");
    $finish;
  end

  // Capacity register clamped to the ring size, zero counts as one slot
  function automatic int usable_slots(input logic [CapW-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > CapW'(MaxSlots)) begin
      return MaxSlots;
    end
    return int'(v);
  endfunction

  // Apply one queue operation to the mirror and return the result it gives
  function automatic queue_result_t apply_queue_op(input logic [1:0] kind,
                                                   input logic signed [DataW-1:0] value,
                                                   input logic [OffW-1:0] off);
    queue_result_t r;
    int            cap;
    r   = '0;
    cap = usable_slots(cap_reg);
    case (kind)
      KIND_PUSH: begin
        if (fill < cap) begin
          tail_q       = (tail_q + 1) % cap;
          ring[tail_q] = value;
          fill++;
          r.accepted = 1'b1;
        end
      end
      KIND_POP: begin
        if (fill != 0) begin
          r.data  = ring[head_q];
          r.valid = 1'b1;
          head_q  = (head_q + 1) % cap;
          fill--;
        end
      end
      KIND_READ: begin
        if (int'(off) < fill) begin
          r.data  = ring[(head_q + int'(off)) % cap];
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      r.head      = ring[head_q];
      r.tail      = ring[tail_q];
      r.not_empty = 1'b1;
    end
    r.count = CntW'(fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checking, capacity tracking and prediction of accepted operations
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, data %0d count %0d",
                   $time, out_read_data, out_entry_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.data, out_read_data);
          check_field("read_valid", want.valid, out_read_valid);
          check_field("push_accepted", want.accepted, out_push_accepted);
          check_field("entry_count", want.count, out_entry_count);
          check_field("head_value", want.head, out_head_value);
          check_field("tail_value", want.tail, out_tail_value);
          check_field("not_empty", want.not_empty, out_not_empty);
        end
      end
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        head_q  = 0;
        tail_q  = usable_slots(cfg_wdata) - 1;
        fill    = 0;
      end
      if (start && !busy) begin
        want = apply_queue_op(in_kind, in_push_value, in_offset);
        if (quiet_op) begin
          want = '0;
        end
        pending_results.push_back(want);
      end
    end
  end

  // Present one operation and hold it until the block takes the transfer
  task automatic send_op(input logic [1:0] kind, input logic signed [DataW-1:0] value,
                         input logic [OffW-1:0] off, input logic quiet);
    start         <= 1'b1;
    in_kind       <= kind;
    in_push_value <= value;
    in_offset     <= off;
    quiet_op      <= quiet;
    do @(posedge clk); while (busy);
    ops_sent++;
  endtask

  // Let every outstanding result come back, then a short settle
  task automatic drain_queue();
    start <= 1'b0;
    while (results_seen < ops_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sender gap before the next operation, with occasional gap-free runs
  task automatic sender_gap(input int idle_pct);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(15) == 0) begin
      burst_left = 10;
    end else begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Random operation, biased to fill or to drain so both ends of the ring get hit
  task automatic random_op();
    int                      pick;
    logic [1:0]              kind;
    logic signed [DataW-1:0] value;
    logic [OffW-1:0]         off;
    if ($urandom_range(19) == 0) begin
      filling = !filling;
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      kind = KindUnused;
    end else if (pick < 15) begin
      kind = KIND_READ;
    end else if ((pick < 72) == filling) begin
      kind = KIND_PUSH;
    end else begin
      kind = KIND_POP;
    end
    case ($urandom_range(15))
      0:       value = 32'sh80000000;
      1:       value = 32'sh7fffffff;
      2:       value = 32'shffffffff;
      3:       value = '0;
      default: value = $urandom;
    endcase
    if (fill > 0 && $urandom_range(9) < 7) begin
      off = OffW'($urandom_range(fill - 1));
    end else begin
      off = OffW'($urandom_range(15));
    end
    send_op(kind, value, off, 1'b0);
  endtask

  initial begin
    int              idle_pct [4];
    logic [CapW-1:0] phase_caps [PhaseCount];
    logic [CapW-1:0] cap;
    idle_pct   = '{0, 48, 0, 13};
    phase_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd3, 5'd16};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty queue, extremes, full, wrap and small capacities
    foreach (dir_ops[i]) begin
      if (dir_ops[i].wr_cap) begin
        drain_queue();
        write_capacity(dir_ops[i].cap);
      end
      send_op(dir_ops[i].kind, dir_ops[i].value, dir_ops[i].off, dir_ops[i].quiet);
    end

    // Random phases, each under its own capacity and sender idling
    for (int p = 0; p < PhaseCount; p++) begin
      drain_queue();
      cap = (p == 7) ? CapW'($urandom_range(1, MaxSlots)) : phase_caps[p];
      write_capacity(cap);
      for (int n = 0; n < PhaseOps; n++) begin
        sender_gap(idle_pct[p % 4]);
        random_op();
      end
    end

    drain_queue();
    repeat (3) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
